// ===== hw/rtl/hvn_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hvn_pkg
// Shared types, register indexes and helpers of the heightmap vertex normal
// block.
// ----------------------------------------------------------------------------
package hvn_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  localparam logic signed [7:0] FACE_UP = 8'sd15;
  localparam logic [15:0] Q_MAX = 16'd32767;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_SUM, S_SQ, S_NSTART, S_NWAIT, S_OUT, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_SQUARE, PH_SCALE, PH_TEST
  } norm_phase_t;

  // floor(b / 20) through a reciprocal; exact for every 8-bit input.
  function automatic logic [3:0] level_of(input logic [7:0] b);
    logic [15:0] p;
    p = {8'd0, b} * 16'd205;
    return p[15:12];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hvn_norm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hvn_norm
// Bit-serial unit scaling: finds the largest q with (2q-1)^2 * n <= mag^2 * 2^32,
// one result bit per pass through the square, scale and test phases.
// ----------------------------------------------------------------------------
module hvn_norm (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [5:0]  mag,
  input  wire logic [13:0] n,
  output logic             done,
  output logic [15:0]      q
);
  import hvn_pkg::*;

  logic              busy;
  norm_phase_t       phase;
  logic [3:0]        bitn;
  logic [5:0]        mag_r;
  logic [13:0]       n_r;
  logic [33:0]       tt;
  logic [47:0]       prod;
  logic [15:0]       cand;
  logic [16:0]       t;
  logic [11:0]       mag_sq;
  logic [47:0]       rhs;

  assign cand   = q | (16'd1 << bitn);
  assign t      = {cand, 1'b0} - 17'd1;
  assign mag_sq = {6'd0, mag_r} * {6'd0, mag_r};
  assign rhs    = {4'd0, mag_sq, 32'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= PH_SQUARE;
    end else begin
      done <= busy && (phase == PH_TEST) && (bitn == 4'd0);
      if (!busy) begin
        if (start) begin
          busy  <= 1'b1;
          phase <= PH_SQUARE;
          bitn  <= 4'd15;
          q     <= '0;
          mag_r <= mag;
          n_r   <= n;
        end
      end else begin
        case (phase)
          PH_SQUARE: begin
            tt    <= 34'(t) * 34'(t);
            phase <= PH_SCALE;
          end
          PH_SCALE: begin
            prod  <= 48'(tt) * 48'(n_r);
            phase <= PH_TEST;
          end
          default: begin
            if (prod <= rhs) q <= cand;
            phase <= PH_SQUARE;
            if (bitn == 4'd0) begin
              busy <= 1'b0;
            end else begin
              bitn <= bitn - 4'd1;
            end
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/heightmap_vertex_normals.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_vertex_normals
// Streams heightmap samples in raster order and emits averaged unit vertex
// normals in signed Q1.15.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on in_valid/in_stall; one transaction moves height_byte.
// Normals leave on out_valid/out_stall from an output register, so the next
// sample is taken while a finished normal still waits downstream.
// Samples of the first row of a frame give no normal. From the second row on,
// each sample gives the normal of the vertex above it; in the last row it
// also gives the normal of its own vertex, flagged with frame_end on the
// final vertex of the frame.
// Sequence: a sample that gives no normal is read from the line buffers and
// retired (with an extra read at the start of a row). Each normal adds the face
// sums and their square sum, then each of three components in the shared
// bit-serial scaling unit (a start, three phases on each of 16 result bits and
// a done) and a load of the output register.
// A cfg transaction (grid_width at index 0, grid_height at index 1) restarts
// the frame; the user must issue it only while the block is idle (unchecked).
// Reset restores 128 x 128 and the start of a frame; no clearing pass.
// A stalled receiver holds the output register and, once a second normal is
// ready, holds the block with it.
// ----------------------------------------------------------------------------
module heightmap_vertex_normals #(
  parameter int MAX_SIDE = 128
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [7:0]                   height_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [15:0]                normal_x,
  output logic signed [15:0]                normal_y,
  output logic signed [15:0]                normal_z,
  output logic                              frame_end,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [hvn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                   cfg_data
);
  import hvn_pkg::*;

  localparam int AW = $clog2(MAX_SIDE);
  localparam int CW = (AW + 1 > 8) ? AW + 1 : 8;

  state_t state, state_next;

  logic [7:0]    grid_width, grid_height;
  logic [AW:0]   w_eff, h_eff;
  logic [CW-1:0] gw_ext, gh_ext;
  logic [AW-1:0] col_pos, row_pos;
  logic [3:0]    prev_lvl, cur_lvl;
  logic          bank;
  logic          second;
  logic          last_col, last_row;

  logic [3:0]    mem_a [MAX_SIDE];
  logic [3:0]    mem_b [MAX_SIDE];
  logic [3:0]    ra, rb, older_rd, newer_rd;
  logic [AW-1:0] rd_addr;

  logic [3:0]    o0, o1, o2, n0, n1, n2;
  logic [3:0]    g [3][3];
  logic [3:0]    pv;
  logic [1:0]    row_en, col_en;
  logic signed [7:0] sx_sum, sy_sum, sz_sum;
  logic signed [7:0] sx, sy, sz;
  logic [13:0]   nsq;
  logic [1:0]    comp;

  logic          norm_start, norm_done;
  logic [15:0]   norm_q, q_sat;
  logic [5:0]    norm_mag;
  logic          comp_neg;
  logic signed [15:0] comp_val;
  logic signed [15:0] res_x, res_y, res_z;
  logic          out_free, cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT);

  // Sizes are clamped to 2..MAX_SIDE.
  assign gw_ext = CW'(grid_width);
  assign gh_ext = CW'(grid_height);
  always_comb begin
    if (gw_ext < CW'(2)) w_eff = (AW+1)'(2);
    else if (gw_ext > CW'(MAX_SIDE)) w_eff = (AW+1)'(MAX_SIDE);
    else w_eff = (AW+1)'(gw_ext);
    if (gh_ext < CW'(2)) h_eff = (AW+1)'(2);
    else if (gh_ext > CW'(MAX_SIDE)) h_eff = (AW+1)'(MAX_SIDE);
    else h_eff = (AW+1)'(gh_ext);
  end

  assign last_col = ({1'b0, col_pos} == w_eff - (AW+1)'(1));
  assign last_row = ({1'b0, row_pos} == h_eff - (AW+1)'(1));
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    norm_start = 1'b0;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = (col_pos == '0) ? S_RD0 : S_RD1;
      S_RD0:    state_next = S_RD1;
      S_RD1:    state_next = (row_pos == '0) ? S_FIN : S_SUM;
      S_SUM:    state_next = S_SQ;
      S_SQ:     state_next = S_NSTART;
      S_NSTART: begin
        norm_start = 1'b1;
        state_next = S_NWAIT;
      end
      S_NWAIT:  if (norm_done) state_next = (comp == COMP_Z) ? S_OUT : S_NSTART;
      S_OUT:    if (out_free) state_next = (!second && last_row) ? S_SUM : S_FIN;
      S_FIN:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Line buffers: the bank bit tells which memory holds the older row.
  assign rd_addr = (state == S_IDLE && col_pos == '0) ? '0 : AW'(col_pos + 1'b1);
  assign older_rd = bank ? rb : ra;
  assign newer_rd = bank ? ra : rb;

  always_ff @(posedge clk) begin
    ra <= mem_a[rd_addr];
    rb <= mem_b[rd_addr];
    if (state == S_RD1) begin
      if (bank) mem_b[col_pos] <= cur_lvl;
      else mem_a[col_pos] <= cur_lvl;
    end
  end

  // Face sums for the vertex above the sample, or for the sample's own vertex
  // on the second pass of the last row.
  always_comb begin
    pv = (col_pos != '0) ? prev_lvl : 4'd0;
    if (!second) begin
      g[0][0] = o0; g[0][1] = o1; g[0][2] = o2;
      g[1][0] = n0; g[1][1] = n1; g[1][2] = n2;
      g[2][0] = pv; g[2][1] = cur_lvl; g[2][2] = 4'd0;
    end else begin
      g[0][0] = n0; g[0][1] = n1; g[0][2] = n2;
      g[1][0] = pv; g[1][1] = cur_lvl; g[1][2] = 4'd0;
      g[2][0] = 4'd0; g[2][1] = 4'd0; g[2][2] = 4'd0;
    end
    row_en[0] = second || ({1'b0, row_pos} >= (AW+1)'(2));
    row_en[1] = !second;
    col_en[0] = (col_pos != '0);
    col_en[1] = !last_col;
    sx_sum = '0;
    sy_sum = '0;
    sz_sum = '0;
    for (int dr = 0; dr < 2; dr++) begin
      for (int dc = 0; dc < 2; dc++) begin
        if (row_en[dr] && col_en[dc]) begin
          sx_sum = sx_sum + ($signed({4'd0, g[dr][dc]}) - $signed({4'd0, g[dr][dc+1]}));
          sy_sum = sy_sum + FACE_UP;
          sz_sum = sz_sum + ($signed({4'd0, g[dr][dc]}) - $signed({4'd0, g[dr+1][dc]}));
        end
      end
    end
  end

  always_comb begin
    case (comp)
      COMP_X:  norm_mag = sx[7] ? 6'(-sx) : 6'(sx);
      COMP_Y:  norm_mag = 6'(sy);
      default: norm_mag = sz[7] ? 6'(-sz) : 6'(sz);
    endcase
    case (comp)
      COMP_X:  comp_neg = sx[7];
      COMP_Y:  comp_neg = sy[7];
      default: comp_neg = sz[7];
    endcase
    q_sat = (norm_q > Q_MAX) ? Q_MAX : norm_q;
    comp_val = comp_neg ? -$signed(q_sat) : $signed(q_sat);
  end

  hvn_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .mag   (norm_mag),
    .n     (nsq),
    .done  (norm_done),
    .q     (norm_q)
  );

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cur_lvl <= level_of(height_byte);
      if (col_pos != '0) begin
        o0 <= o1; o1 <= o2;
        n0 <= n1; n1 <= n2;
      end
    end
    if (state == S_RD0) begin
      o0 <= 4'd0; o1 <= older_rd;
      n0 <= 4'd0; n1 <= newer_rd;
    end
    if (state == S_RD1) begin
      o2 <= older_rd;
      n2 <= newer_rd;
    end
    if (state == S_SUM) begin
      sx <= sx_sum;
      sy <= sy_sum;
      sz <= sz_sum;
    end
    if (state == S_SQ) begin
      nsq <= 14'(16'(sx * sx) + 16'(sy * sy) + 16'(sz * sz));
    end
    if (state == S_NWAIT && norm_done) begin
      case (comp)
        COMP_X:  res_x <= comp_val;
        COMP_Y:  res_y <= comp_val;
        default: res_z <= comp_val;
      endcase
    end
    if (state == S_OUT && out_free) begin
      normal_x  <= res_x;
      normal_y  <= res_y;
      normal_z  <= res_z;
      frame_end <= second && last_col;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 8'd128;
      grid_height <= 8'd128;
      col_pos     <= '0;
      row_pos     <= '0;
      prev_lvl    <= '0;
      bank        <= 1'b0;
      second      <= 1'b0;
      comp        <= COMP_X;
      out_valid   <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == S_OUT && out_free && !second && last_row) second <= 1'b1;
      if (state == S_FIN) second <= 1'b0;
      if (state == S_SQ) comp <= COMP_X;
      if (state == S_NWAIT && norm_done) comp <= comp + 2'd1;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_GRID_WIDTH:  grid_width  <= cfg_data;
          REG_GRID_HEIGHT: grid_height <= cfg_data;
          default: ;
        endcase
      end
      if (cfg_we) begin
        col_pos  <= '0;
        row_pos  <= '0;
        prev_lvl <= '0;
      end else if (state == S_FIN) begin
        if (last_col) begin
          col_pos  <= '0;
          prev_lvl <= '0;
          bank     <= ~bank;
          row_pos  <= last_row ? '0 : AW'(row_pos + 1'b1);
        end else begin
          col_pos  <= AW'(col_pos + 1'b1);
          prev_lvl <= cur_lvl;
        end
      end
    end
  end

`ifndef SYNTH
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, col_pos} < w_eff)
    else $error("column position beyond grid width");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, row_pos} < h_eff)
    else $error("row position beyond grid height");

  a_norm_done_waited: assert property (@(posedge clk) disable iff (rst)
    norm_done |-> state == S_NWAIT)
    else $error("scaling result arrived while not awaited");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && last_col && last_row && !cfg_we) |=>
      (col_pos == '0 && row_pos == '0))
    else $error("frame did not wrap after its last sample");
`endif

endmodule
`default_nettype wire
